// ===== design/htx_pkg.sv =====
package htx_pkg;

   localparam int DATA_W            = 32;
   localparam int ACC_W             = 2 * DATA_W + 2;
   localparam int CELLS             = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int REQ_DATA_W        = 168;
   localparam int RSP_DATA_W        = 4 * DATA_W;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_VECTOR = 2'd1,
      MODE_POINT  = 2'd2,
      MODE_ROW    = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                         mode;
      logic [3:0]                       entry_index;
      logic [DATA_W-1:0]                entry_value;
      logic [CELLS-1:0][DATA_W-1:0]     vec;
   } item_type;

   // one request on its way down the chain, with the partial sums it has gathered
   typedef struct packed {
      item_type                         item;
      logic [CELLS-1:0][ACC_W-1:0]      acc;
   } link_type;

endpackage

// ===== design/homogeneous_transform_4x4_unit.sv =====
// 4x4 homogeneous transform, signed fixed point with FRAC_BITS fraction bits.
//
// Request channel (req_*): tuser carries the mode (load entry, column vector,
// point, row vector); tdata carries the entry index and value and the four
// vector components. A load writes one matrix entry and gives no response;
// every other request gives one response on rsp_*: x, y, z, w in tdata and
// the saturation flag in tuser.
//
// The datapath is a row of four cells, one per vector component. Each cell
// holds one column and one row of the matrix, registers its products, and adds
// them into the passing partial sums in its add register. Loads travel the
// same chain, so requests see the matrix in request order.
// A request passes each cell's product and add registers and then the output
// register; one request is taken every cycle while nothing stalls. A stalled
// response holds in the output register; idle stages ahead of it still fill,
// and req_tready drops only once the chain is full.
// Reset empties the chain and restores the identity matrix.
module homogeneous_transform_4x4_unit #(
   parameter int FRAC_BITS = htx_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index[3:0], entry_value[35:4], vec_x[67:36], vec_y[99:68],
   // vec_z[131:100], vec_w[163:132], zero fill [167:164]
   input  logic [htx_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   output logic [htx_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // saturated[0]
   output logic [0:0]                        rsp_tuser
);
   import htx_pkg::*;

   localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

   logic     chain_valid [CELLS+1];
   logic     chain_ready [CELLS+1];
   link_type chain_link  [CELLS+1];
   mode_type req_mode;

   assign req_mode = mode_type'(req_tuser);

   always_comb begin
      chain_link[0]                  = '0;
      chain_link[0].item.mode        = req_mode;
      chain_link[0].item.entry_index = req_tdata[3:0];
      chain_link[0].item.entry_value = req_tdata[35:4];
      chain_link[0].item.vec[0]      = req_tdata[67:36];
      chain_link[0].item.vec[1]      = req_tdata[99:68];
      chain_link[0].item.vec[2]      = req_tdata[131:100];
      chain_link[0].item.vec[3]      = (req_mode == MODE_POINT) ? ONE_FX : req_tdata[163:132];
   end

   assign chain_valid[0] = req_tvalid;
   assign req_tready     = chain_ready[0];

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      htx_cell #(
         .CELL_INDEX (k),
         .FRAC_BITS  (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_link   (chain_link[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_link  (chain_link[k+1])
      );
   end

   htx_finish #(
      .FRAC_BITS (FRAC_BITS)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[CELLS]),
      .in_ready   (chain_ready[CELLS]),
      .in_link    (chain_link[CELLS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== design/htx_cell.sv =====
module htx_cell #(
   parameter int CELL_INDEX = 0,
   parameter int FRAC_BITS  = htx_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  htx_pkg::link_type in_link,
   output logic              out_valid,
   input  logic              out_ready,
   output htx_pkg::link_type out_link
);
   import htx_pkg::*;

   localparam logic [1:0]        CELL_SEL = 2'(CELL_INDEX);
   localparam logic [DATA_W-1:0] ONE_FX   = DATA_W'(1) << FRAC_BITS;

   // column CELL_INDEX and row CELL_INDEX of the matrix
   logic signed [DATA_W-1:0] col_ff [CELLS];
   logic signed [DATA_W-1:0] col_in [CELLS];
   logic signed [DATA_W-1:0] row_ff [CELLS];
   logic signed [DATA_W-1:0] row_in [CELLS];

   logic                       a_valid_ff;
   link_type                   a_link_ff;
   logic signed [2*DATA_W-1:0] a_prod_ff [CELLS];
   logic signed [2*DATA_W-1:0] a_prod_in [CELLS];
   logic                       b_valid_ff;
   link_type                   b_link_ff;
   link_type                   b_link_in;

   logic a_ready;
   logic b_ready;
   logic move_a;
   logic signed [DATA_W-1:0] vk;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;
   assign move_a   = in_valid && a_ready;

   assign vk = $signed(in_link.item.vec[CELL_INDEX]);

   always_comb begin
      for (int r = 0; r < CELLS; r++) begin
         a_prod_in[r] = (in_link.item.mode == MODE_ROW) ? row_ff[r] * vk : col_ff[r] * vk;
      end
   end

   // loads ride the chain so that earlier requests keep the matrix they were sent against
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (move_a && in_link.item.mode == MODE_LOAD) begin
         if (in_link.item.entry_index[3:2] == CELL_SEL) begin
            col_in[in_link.item.entry_index[1:0]] = $signed(in_link.item.entry_value);
         end
         if (in_link.item.entry_index[1:0] == CELL_SEL) begin
            row_in[in_link.item.entry_index[3:2]] = $signed(in_link.item.entry_value);
         end
      end
   end

   always_comb begin
      b_link_in = a_link_ff;
      for (int r = 0; r < CELLS; r++) begin
         b_link_in.acc[r] = a_link_ff.acc[r] + ACC_W'(a_prod_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         for (int j = 0; j < CELLS; j++) begin
            col_ff[j] <= (j == CELL_INDEX) ? ONE_FX : '0;
            row_ff[j] <= (j == CELL_INDEX) ? ONE_FX : '0;
         end
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_link_ff <= in_link;
         a_prod_ff <= a_prod_in;
      end
      if (b_ready) begin
         b_link_ff <= b_link_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_link  = b_link_ff;

endmodule

// ===== design/htx_finish.sv =====
module htx_finish #(
   parameter int FRAC_BITS = htx_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  htx_pkg::link_type                 in_link,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [htx_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser
);
   import htx_pkg::*;

   localparam logic [DATA_W-1:0] ONE_FX  = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   logic                          valid_ff;
   logic [RSP_DATA_W-1:0]         data_ff;
   logic [RSP_DATA_W-1:0]         data_in;
   logic                          sat_ff;
   logic                          sat_in;
   logic [CELLS-1:0]              clip;
   logic [CELLS-1:0][DATA_W-1:0]  comp;
   logic signed [ACC_W-1:0]       shifted [CELLS];

   assign in_ready = !valid_ff || rsp_tready;

   // floor shift, then clip to 32 bits when the upper bits are not a sign run
   always_comb begin
      for (int r = 0; r < CELLS; r++) begin
         shifted[r] = $signed(in_link.acc[r]) >>> FRAC_BITS;
         clip[r]    = !(&shifted[r][ACC_W-1:DATA_W-1] || ~|shifted[r][ACC_W-1:DATA_W-1]);
         if (clip[r]) begin
            comp[r] = shifted[r][ACC_W-1] ? MIN_VAL : MAX_VAL;
         end else begin
            comp[r] = shifted[r][DATA_W-1:0];
         end
      end
   end

   always_comb begin
      data_in = {comp[3], comp[2], comp[1], comp[0]};
      sat_in  = clip[0] | clip[1] | clip[2];
      case (in_link.item.mode)
         MODE_VECTOR: sat_in = sat_in | clip[3];
         MODE_POINT:  data_in[4*DATA_W-1:3*DATA_W] = ONE_FX;
         MODE_ROW:    data_in[4*DATA_W-1:3*DATA_W] = '0;
         default:     sat_in = sat_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid && in_link.item.mode != MODE_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = sat_ff;

endmodule

// ===== design/htx_checker.sv =====
module htx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [htx_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [0:0]                        rsp_tuser
);
   import htx_pkg::*;

   localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // the flag only comes with a clipped component
   a_sat_clip: assert property (@(posedge clock)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[31:0]   == MAX_VAL || rsp_tdata[31:0]   == MIN_VAL ||
         rsp_tdata[63:32]  == MAX_VAL || rsp_tdata[63:32]  == MIN_VAL ||
         rsp_tdata[95:64]  == MAX_VAL || rsp_tdata[95:64]  == MIN_VAL ||
         rsp_tdata[127:96] == MAX_VAL || rsp_tdata[127:96] == MIN_VAL)
      else $error("saturation flag without a clipped component");

   // with the output draining, no stage can hold the chain back
   a_ready_flow: assert property (@(posedge clock) rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

   // reset empties the chain
   a_reset_empty: assert property (@(posedge clock) reset |=> req_tready && !rsp_tvalid)
      else $error("chain not empty after reset");

endmodule

bind homogeneous_transform_4x4_unit htx_checker u_htx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
